### design/b2da_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds constants, the controller state type and the control/status structs.
// No dependencies.
`default_nettype none

package b2da_pkg;

   localparam int MAX_DIGITS  = 10;
   localparam int WORD_DIGITS = 10;
   localparam int BUF_IDX_W   = $clog2(WORD_DIGITS);
   localparam int KEEP_MAX    = MAX_DIGITS - 1;

   localparam logic [5:0]  ASCII_ZERO  = 6'd48;
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic emit_last;
   } status_type;

endpackage

`default_nettype wire

### design/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_ctrl and b2da_datapath.
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+------------------------
//   request   | req_value[31:0]                         | start & !busy
//   response  | rsp_digit_char[5:0], rsp_last_digit     | rsp_strobe, one cycle
//
// A transaction of n digits (n = 1..10) first runs through the divide-by-ten
// unit, one digit per cycle, then emits its n digits on the response channel.
// The divide step uses a reciprocal multiplier.
// busy drops in the cycle after the last digit; start is taken then.
// Synchronous reset returns the controller to idle; no digit is in flight.
// Digits leave on consecutive cycles; the receiver cannot stall them.
`default_nettype none

module binary_to_decimal_ascii
   import b2da_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [31:0] req_value,
   output      logic        rsp_strobe,
   output      logic [5:0]  rsp_digit_char,
   output      logic        rsp_last_digit
);

   cmd_type    cmd;
   status_type status;

   b2da_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   b2da_datapath u_datapath (
      .clock          (clock),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

`ifndef SYNTHESIS
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_idle_quiet : assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_strobe)
      else $error("digit strobe while idle");

   a_run_contig : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_digit) |=> rsp_strobe)
      else $error("digit run broken before last digit");

   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_digit) |=> !busy)
      else $error("busy held after last digit");

   a_char_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_digit_char >= 6'd48 && rsp_digit_char <= 6'd57))
      else $error("digit character out of range");
`endif

endmodule

`default_nettype wire

### design/b2da_datapath.sv
// Datapath: value register, divide-by-ten unit, digit buffer and emit index.
// Depends on b2da_pkg.
`default_nettype none

module b2da_datapath
   import b2da_pkg::*;
(
   input  wire logic        clock,
   input  wire logic [31:0] req_value,
   input  wire cmd_type     cmd,
   output      status_type  status,
   output      logic [5:0]  rsp_digit_char,
   output      logic        rsp_last_digit
);

   logic [31:0]          value_ff, value_in;
   logic [BUF_IDX_W-1:0] count_ff, count_in;
   logic [BUF_IDX_W-1:0] idx_ff, idx_in;
   logic [3:0]           digits_ff [WORD_DIGITS];

   logic [63:0] product;
   logic [31:0] quot;
   logic [31:0] quot_x10;
   logic [31:0] diff;
   logic [3:0]  rem;

   // floor(v / 10) by reciprocal multiply, exact over all 32-bit values
   assign product  = 64'(value_ff) * 64'(RECIP_TEN);
   assign quot     = 32'(product[63:RECIP_SHIFT]);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign diff     = value_ff - quot_x10;
   assign rem      = diff[3:0];

   always_comb begin
      value_in = value_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      if (cmd.load) begin
         value_in = req_value;
         count_in = '0;
      end else if (cmd.div_step) begin
         value_in = quot;
         count_in = count_ff + 1'b1;
         if (int'(count_ff) > KEEP_MAX) begin
            idx_in = BUF_IDX_W'(KEEP_MAX);
         end else begin
            idx_in = count_ff;
         end
      end else if (cmd.emit_step) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
      if (cmd.div_step) begin
         digits_ff[count_ff] <= rem;
      end
   end

   assign status.div_done  = (quot == '0) || (int'(count_ff) == WORD_DIGITS - 1);
   assign status.emit_last = (idx_ff == '0);

   assign rsp_digit_char = ASCII_ZERO + {2'b00, digits_ff[idx_ff]};
   assign rsp_last_digit = (idx_ff == '0);

endmodule

`default_nettype wire

### design/b2da_ctrl.sv
// Controller state machine: load, convert (one digit per cycle), emit.
// Depends on b2da_pkg.
`default_nettype none

module b2da_ctrl
   import b2da_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output      cmd_type    cmd,
   output      logic       busy,
   output      logic       rsp_strobe
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CONVERT: begin
            cmd.div_step = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit_step = 1'b1;
            rsp_strobe    = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
